/* rtl/csu_pkg.sv */
// shared constants for the command driven character stack
package csu_pkg;

  parameter int STACK_DEPTH = 64;

  localparam logic [7:0] CMD_PUSH = 8'h3C;  // '<'
  localparam logic [7:0] CMD_POP  = 8'h3E;  // '>'
  localparam logic [7:0] CMD_DUMP = 8'h7C;  // '|'

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_UNDERFLOW = 2'd1;
  localparam logic [1:0] KIND_OVERFLOW  = 2'd2;

endpackage

/* rtl/csu_stack_mem.sv */
// byte-wide stack storage, one write port and one registered read port
module csu_stack_mem #(
  parameter int DEPTH  = csu_pkg::STACK_DEPTH,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/command_driven_char_stack_unit.sv */
// top level: command sequencer around the stack memory and its shared count unit
//
//  channel   signals                                  transfer
//  command   start, busy, in_byte                     start high while busy low
//  result    out_valid, out_byte, result_kind, last   out_valid high, one cycle
//
// push, pop and ignored bytes keep busy low; the result of a pop on empty or a push
// on full shows in the cycle after the transfer.
// a dump keeps busy high while the count unit walks the memory read port from the top down;
// each read byte passes through the memory read register and then the output register.
// rst (synchronous) empties the stack and clears a pending push; memory is not cleared.
// the receiver cannot stall: each result is shown for exactly one cycle.
module command_driven_char_stack_unit #(
  parameter int STACK_DEPTH = csu_pkg::STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [1:0] result_kind,
  output logic       last
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic             state;
  logic             state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             push_pending;
  logic             push_pending_next;

  logic             res_valid_next;
  logic [7:0]       res_byte_next;
  logic [1:0]       res_kind_next;
  logic             res_last_next;

  logic             accept;
  logic             full;
  logic             empty;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;

  logic             wr_en;
  logic             rd_en;
  logic [7:0]       rd_data;

  assign accept    = start && (state == ST_IDLE);
  assign busy      = (state != ST_IDLE);
  assign full      = (count == CNT_W'(STACK_DEPTH));
  assign empty     = (count == '0);
  // one incrementer and one shared decrementer for the stack pointer
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);

  always_comb begin
    state_next        = state;
    count_next        = count;
    push_pending_next = push_pending;
    res_valid_next    = 1'b0;
    res_byte_next     = 8'h00;
    res_kind_next     = csu_pkg::KIND_DATA;
    res_last_next     = 1'b0;
    wr_en             = 1'b0;
    rd_en             = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (push_pending) begin
            push_pending_next = 1'b0;
            if (full) begin
              res_valid_next = 1'b1;
              res_kind_next  = csu_pkg::KIND_OVERFLOW;
              res_last_next  = 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_next = count_inc;
            end
          end else if (in_byte == csu_pkg::CMD_PUSH) begin
            push_pending_next = 1'b1;
          end else if (in_byte == csu_pkg::CMD_POP) begin
            if (empty) begin
              res_valid_next = 1'b1;
              res_kind_next  = csu_pkg::KIND_UNDERFLOW;
              res_last_next  = 1'b1;
            end else begin
              count_next = count_dec;
            end
          end else if (in_byte == csu_pkg::CMD_DUMP) begin
            if (!empty) begin
              rd_en      = 1'b1;
              count_next = count_dec;
              state_next = ST_DUMP;
            end
          end
        end
      end
      ST_DUMP: begin
        // rd_data holds the entry at index count
        res_valid_next = 1'b1;
        res_byte_next  = rd_data;
        res_last_next  = empty;
        if (empty) begin
          state_next = ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          count_next = count_dec;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      push_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      push_pending <= push_pending_next;
      out_valid    <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_byte    <= res_byte_next;
    result_kind <= res_kind_next;
    last        <= res_last_next;
  end

  csu_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (in_byte),
    .rd_en   (rd_en),
    .rd_addr (count_dec[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind != csu_pkg::KIND_DATA) |-> last)
    else $error("error result not marked last");

  a_data_from_dump: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == csu_pkg::KIND_DATA) |-> $past(state) == ST_DUMP)
    else $error("data result outside a dump");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) && empty |=> (state == ST_IDLE) && out_valid && last)
    else $error("dump did not close with a last result");
`endif

endmodule

/* tb/sv/command_driven_char_stack_unit_tb.sv */
// self-checking testbench for the command driven character stack unit
module command_driven_char_stack_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 380;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       tail;
  } stack_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic       busy;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic [7:0] out_byte;
  logic [1:0] result_kind;
  logic       result_last;

  command_driven_char_stack_unit dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_byte   (out_byte),
    .result_kind(result_kind),
    .last       (result_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // command bytes waiting to go out, and results the stack still owes us
  logic [7:0]    pending_bytes[$];
  stack_result_t expected_results[$];

  // shadow of the stack
  logic [7:0]  shadow_stack[csu_pkg::STACK_DEPTH];
  int unsigned stored_count = 0;
  bit          push_armed = 1'b0;

  bit took_item = 1'b0;
  int idle_left = 0;
  bit burst_mode = 1'b0;

  int mismatch_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int dumped_count = 0;
  int underflow_count = 0;
  int overflow_count = 0;
  int deepest = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic apply_command(input logic [7:0] b);
    if (push_armed) begin
      // armed byte is data even when it looks like a command
      push_armed = 1'b0;
      if (stored_count >= csu_pkg::STACK_DEPTH) begin
        expected_results.push_back('{data: 8'h00, kind: csu_pkg::KIND_OVERFLOW,
                                     tail: 1'b1});
      end else begin
        shadow_stack[stored_count] = b;
        stored_count++;
        if (stored_count > deepest) deepest = stored_count;
      end
    end else if (b == csu_pkg::CMD_PUSH) begin
      push_armed = 1'b1;
    end else if (b == csu_pkg::CMD_POP) begin
      if (stored_count == 0)
        expected_results.push_back('{data: 8'h00, kind: csu_pkg::KIND_UNDERFLOW,
                                     tail: 1'b1});
      else
        stored_count--;
    end else if (b == csu_pkg::CMD_DUMP) begin
      while (stored_count > 0) begin
        stored_count--;
        expected_results.push_back('{data: shadow_stack[stored_count],
                                     kind: csu_pkg::KIND_DATA,
                                     tail: (stored_count == 0)});
      end
    end
  endtask

  task automatic check_result();
    stack_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result byte %h kind %0d last %b",
                                out_byte, result_kind, result_last));
    end else begin
      want = expected_results.pop_front();
      checked_count++;
      if (out_byte !== want.data)
        report_mismatch($sformatf("out_byte %h, expected %h", out_byte, want.data));
      if (result_kind !== want.kind)
        report_mismatch($sformatf("result_kind %0d, expected %0d", result_kind, want.kind));
      if (result_last !== want.tail)
        report_mismatch($sformatf("last %b, expected %b", result_last, want.tail));
      case (want.kind)
        csu_pkg::KIND_UNDERFLOW: underflow_count++;
        csu_pkg::KIND_OVERFLOW:  overflow_count++;
        default:                 dumped_count++;
      endcase
    end
  endtask

  // monitor: transfers and results are both seen at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      took_item = 1'b0;
    end else begin
      took_item = start && !busy;
      if (took_item) apply_command(in_byte);
      if (out_valid) check_result();
    end
  end

  // driver: holds a command until its transfer, then waits its drawn gap
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !took_item)) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_byte <= pending_bytes.pop_front();
        start <= 1'b1;
        sent_count++;
        idle_left = burst_mode ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 11))
      0:       return csu_pkg::CMD_PUSH;
      1:       return csu_pkg::CMD_POP;
      2:       return csu_pkg::CMD_DUMP;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int fill_at;
    int pick;
    bit filled;

    // directed opening: errors on empty, command codes as data, dump order
    pending_bytes = '{csu_pkg::CMD_POP, csu_pkg::CMD_DUMP, 8'h00, 8'hFF,
                      csu_pkg::CMD_PUSH, 8'h00, csu_pkg::CMD_PUSH, 8'hFF,
                      csu_pkg::CMD_PUSH, csu_pkg::CMD_PUSH,
                      csu_pkg::CMD_PUSH, csu_pkg::CMD_POP, csu_pkg::CMD_PUSH,
                      csu_pkg::CMD_DUMP, csu_pkg::CMD_POP,
                      csu_pkg::CMD_PUSH, 8'hA5, csu_pkg::CMD_DUMP, csu_pkg::CMD_POP};

    filled = 1'b0;
    fill_at = $urandom_range(60, 180);
    while (pending_bytes.size() < ITEM_TARGET) begin
      if (!filled && pending_bytes.size() >= fill_at) begin
        // two dumps leave the stack empty even if a push was armed
        pending_bytes.push_back(csu_pkg::CMD_DUMP);
        pending_bytes.push_back(csu_pkg::CMD_DUMP);
        repeat (csu_pkg::STACK_DEPTH + 2) begin
          pending_bytes.push_back(csu_pkg::CMD_PUSH);
          pending_bytes.push_back(pick_data());
        end
        pending_bytes.push_back(csu_pkg::CMD_POP);
        pending_bytes.push_back(csu_pkg::CMD_DUMP);
        filled = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pending_bytes.push_back(csu_pkg::CMD_PUSH);
        pending_bytes.push_back(pick_data());
      end else if (pick < 63) begin
        pending_bytes.push_back(csu_pkg::CMD_POP);
      end else if (pick < 72) begin
        pending_bytes.push_back(csu_pkg::CMD_DUMP);
      end else begin
        pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    pending_bytes.push_back(csu_pkg::CMD_DUMP);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_bytes.size() == 0 && !start);
    wait (expected_results.size() == 0);
    // a dump can still be draining if its last results were already predicted
    repeat (csu_pkg::STACK_DEPTH + 8) @(posedge clk);

    $display("sent %0d command bytes, checked %0d results:", sent_count, checked_count);
    $display("%0d dumped, %0d underflow, %0d overflow; stack reached %0d of %0d",
             dumped_count, underflow_count, overflow_count, deepest,
             csu_pkg::STACK_DEPTH);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout after %0t", $realtime);
    $display("status: fail");
    $finish;
  end

endmodule
